@@ design/cansf_pkg.sv @@
`timescale 1ns / 1ps

package cansf_pkg;

	// bank table size and derived widths
	localparam int NUM_BANKS = 16;
	localparam int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int CNT_W     = $clog2(NUM_BANKS + 1);

	// split register
	localparam int                 SPLIT_W     = 5;
	localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(16);

	// input operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// frame word bit 0 is dropped before compare
	localparam logic [31:0] FRAME_MASK = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		VERDICT_WRITTEN  = 2'd0,
		VERDICT_ACCEPTED = 2'd1,
		VERDICT_REJECTED = 2'd2,
		VERDICT_STOPPED  = 2'd3
	} verdict_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// one bank as stored in the table ram
	typedef struct packed {
		logic        mode;
		logic        scale;
		logic [31:0] id_word;
		logic [31:0] mask_word;
	} bank_entry_t;

	// compare unit result
	typedef struct packed {
		logic accept;
		logic stop;
	} match_res_t;

endpackage

@@ design/cansf_ram.sv @@
`timescale 1ns / 1ps

module cansf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/cansf_match.sv @@
`timescale 1ns / 1ps

module cansf_match (
	input  cansf_pkg::bank_entry_t bank,
	input  logic [31:0]            frame,
	output cansf_pkg::match_res_t  res
);

	logic list_hit;
	logic mask_hit;

	// list mode: either stored word equals the frame
	assign list_hit = (bank.id_word == frame) || (bank.mask_word == frame);
	// mask mode: masked bits agree
	assign mask_hit = ((bank.id_word ^ frame) & bank.mask_word) == 32'd0;

	// sixteen-bit scale is unsupported and halts the scan
	always_comb begin
		res.stop   = ~bank.scale;
		res.accept = bank.scale & (bank.mode ? list_hit : mask_hit);
	end

endmodule

@@ design/can_soft_acceptance_filter.sv @@
`timescale 1ns / 1ps

// CAN acceptance filter over a table of 32-bit filter banks.
// Command channel: an item is taken at a clock edge with start high and busy
// low. op selects a bank write (bank_index, bank_enable, filter_mode,
// filter_scale, first_word, second_word) or a frame check (controller,
// frame_word). Every item gives exactly one result: verdict and matched_bank
// are valid for the single cycle in which done is high.
// A bank write completes at the accept edge; done follows in the next cycle
// and busy never rises, so writes can be issued every cycle.
// A frame check walks its controller's bank range one bank per cycle through
// the table's single read port and one shared compare unit. busy stays high
// while the scan runs, and done comes in the cycle busy drops. Scanning
// stops early at the first enabled bank that accepts or has an unsupported
// scale.
// cfg_we / cfg_wdata load second_start_bank; write it only while idle.
// Reset clears every bank enable and sets second_start_bank to 16; bank
// contents are not cleared. The receiver cannot stall: each result beat is
// offered once.
module can_soft_acceptance_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic        controller,
	input  logic [3:0]  bank_index,
	input  logic        bank_enable,
	input  logic        filter_mode,
	input  logic        filter_scale,
	input  logic [31:0] first_word,
	input  logic [31:0] second_word,
	input  logic [31:0] frame_word,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [3:0]  matched_bank
);

	cansf_pkg::state_t      state_q, state_d;
	logic [4:0]             split_q;
	logic [cansf_pkg::NUM_BANKS-1:0] bank_en_q;
	logic [cansf_pkg::CNT_W-1:0]     rd_idx_q, hi_q;
	logic [cansf_pkg::CNT_W-1:0]     split_clamp, lo_d, hi_d;
	logic [31:0]            frame_q;
	logic                   rd_valid_s1, en_s1;
	logic [cansf_pkg::BANK_W-1:0]    bank_s1;
	logic                   done_q, done_d;
	cansf_pkg::verdict_t    verdict_q, verdict_d;
	logic [3:0]             matched_q, matched_d;

	logic                   accept, wr_en, rd_go, hit_s1, finish_miss;
	logic [cansf_pkg::BANK_W-1:0]    waddr, raddr;
	cansf_pkg::bank_entry_t wr_entry, rd_entry;
	cansf_pkg::match_res_t  mres;

	assign busy   = (state_q == cansf_pkg::ST_SCAN);
	assign accept = start & ~busy;
	assign wr_en  = accept && (op == cansf_pkg::OP_WRITE)
		&& (32'(bank_index) < 32'(cansf_pkg::NUM_BANKS));
	assign waddr  = cansf_pkg::BANK_W'(bank_index);
	assign raddr  = rd_idx_q[cansf_pkg::BANK_W-1:0];

	always_comb begin
		wr_entry.mode      = filter_mode;
		wr_entry.scale     = filter_scale;
		wr_entry.id_word   = first_word;
		wr_entry.mask_word = second_word;
	end

	// scan range for the incoming frame
	always_comb begin
		if (32'(split_q) > 32'(cansf_pkg::NUM_BANKS)) begin
			split_clamp = cansf_pkg::CNT_W'(cansf_pkg::NUM_BANKS);
		end else begin
			split_clamp = cansf_pkg::CNT_W'(split_q);
		end
		lo_d = controller ? split_clamp : '0;
		hi_d = controller ? cansf_pkg::CNT_W'(cansf_pkg::NUM_BANKS) : split_clamp;
	end

	cansf_ram #(
		.WIDTH ($bits(cansf_pkg::bank_entry_t)),
		.DEPTH (cansf_pkg::NUM_BANKS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	cansf_match u_match (
		.bank  (rd_entry),
		.frame (frame_q),
		.res   (mres)
	);

	// scan control
	assign hit_s1      = rd_valid_s1 & en_s1 & (mres.accept | mres.stop);
	assign finish_miss = busy & ~hit_s1 & (rd_idx_q >= hi_q);
	assign rd_go       = busy & ~hit_s1 & (rd_idx_q < hi_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cansf_pkg::ST_IDLE: begin
				if (accept && (op == cansf_pkg::OP_FRAME)) begin
					state_d = cansf_pkg::ST_SCAN;
				end
			end
			cansf_pkg::ST_SCAN: begin
				if (hit_s1 || finish_miss) begin
					state_d = cansf_pkg::ST_IDLE;
				end
			end
			default: state_d = cansf_pkg::ST_IDLE;
		endcase
	end

	// result beat
	always_comb begin
		done_d    = 1'b0;
		verdict_d = cansf_pkg::VERDICT_WRITTEN;
		matched_d = 4'd0;
		unique case (state_q)
			cansf_pkg::ST_IDLE: begin
				if (accept && (op == cansf_pkg::OP_WRITE)) begin
					done_d = 1'b1;
				end
			end
			cansf_pkg::ST_SCAN: begin
				if (hit_s1) begin
					done_d    = 1'b1;
					verdict_d = mres.stop ? cansf_pkg::VERDICT_STOPPED
						: cansf_pkg::VERDICT_ACCEPTED;
					matched_d = 4'(bank_s1);
				end else if (finish_miss) begin
					done_d    = 1'b1;
					verdict_d = cansf_pkg::VERDICT_REJECTED;
				end
			end
			default: done_d = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cansf_pkg::ST_IDLE;
			split_q     <= cansf_pkg::SPLIT_RESET;
			bank_en_q   <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_go;
			done_q      <= done_d;
			if (cfg_we) begin
				split_q <= cfg_wdata;
			end
			if (wr_en) begin
				bank_en_q[waddr] <= bank_enable;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && (op == cansf_pkg::OP_FRAME)) begin
			rd_idx_q <= lo_d;
			hi_q     <= hi_d;
			frame_q  <= frame_word & cansf_pkg::FRAME_MASK;
		end else if (rd_go) begin
			rd_idx_q <= rd_idx_q + cansf_pkg::CNT_W'(1);
		end
		en_s1     <= bank_en_q[raddr];
		bank_s1   <= raddr;
		verdict_q <= verdict_d;
		matched_q <= matched_d;
	end

	assign done         = done_q;
	assign verdict      = verdict_q;
	assign matched_bank = matched_q;

endmodule

@@ design/cansf_checker.sv @@
`timescale 1ns / 1ps

module cansf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       op,
	input logic       done,
	input logic [1:0] verdict,
	input logic [3:0] matched_bank
);

	// a bank write answers in the next cycle
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == cansf_pkg::OP_WRITE)
		|=> done && (verdict == cansf_pkg::VERDICT_WRITTEN))
		else $error("bank write did not answer in the next cycle");

	// a frame check always occupies the block
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == cansf_pkg::OP_FRAME) |=> busy)
		else $error("frame check did not raise busy");

	// no result beat while scanning
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat during scan");

	// end of scan delivers a frame verdict
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && (verdict != cansf_pkg::VERDICT_WRITTEN))
		else $error("scan ended without a frame verdict");

	// writes and rejects report bank zero
	a_bank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((verdict == cansf_pkg::VERDICT_WRITTEN)
			|| (verdict == cansf_pkg::VERDICT_REJECTED)) |-> matched_bank == 4'd0)
		else $error("nonzero bank on write or reject");

endmodule

bind can_soft_acceptance_filter cansf_checker u_cansf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.verdict      (verdict),
	.matched_bank (matched_bank)
);
